/* rtl/psd_pkg.sv */
`default_nettype none
package psd_pkg;
  localparam int unsigned FracBits = 12;
  localparam int unsigned TBits = 32;
  localparam int unsigned SqrtBits = 36;
  localparam logic [31:0] TolReset = 32'd1;

  typedef enum logic [1:0] {
    POS_WITHIN = 2'd0,
    POS_BEFORE = 2'd1,
    POS_PAST   = 2'd2
  } pos_e;

  // Which point the nearest point is taken from.
  typedef enum logic [1:0] {
    SEL_START = 2'd0,
    SEL_END   = 2'd1,
    SEL_INNER = 2'd2
  } sel_e;

  // Data carried down the cell chain.
  typedef struct packed {
    logic signed [32:0] px, py, pz;
    logic signed [32:0] sx, sy, sz;
    logic signed [32:0] dx, dy, dz;
    logic               use_z;
    logic               degen;
  } geom_t;

  typedef struct packed {
    logic [31:0] t;
    logic [69:0] rem;
    logic [69:0] den;
  } div_t;

  typedef struct packed {
    logic [63:0] dist2;
    logic [71:0] rad;
    logic [35:0] rem;
    logic [35:0] root;
    logic signed [31:0] nx, ny, nz;
    pos_e        pos;
  } res_t;
endpackage
`default_nettype wire

/* rtl/psd_div_cell.sv */
`default_nettype none
// One restoring division step of t = floor(num * 2^32 / den).
module psd_div_cell (
  input  wire                 clk_i,
  input  wire                 en_i,
  input  psd_pkg::div_t       div_i,
  input  psd_pkg::geom_t      geom_i,
  input  psd_pkg::pos_e       pos_i,
  input  psd_pkg::sel_e       sel_i,
  output psd_pkg::div_t       div_o,
  output psd_pkg::geom_t      geom_o,
  output psd_pkg::pos_e       pos_o,
  output psd_pkg::sel_e       sel_o
);
  import psd_pkg::*;
  logic [70:0] sh;
  div_t        nxt;

  always_comb begin
    sh = {div_i.rem, 1'b0};
    nxt.den = div_i.den;
    if (sh >= {1'b0, div_i.den}) begin
      nxt.rem = 70'(sh - {1'b0, div_i.den});
      nxt.t = {div_i.t[30:0], 1'b1};
    end else begin
      nxt.rem = sh[69:0];
      nxt.t = {div_i.t[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_o  <= nxt;
      geom_o <= geom_i;
      pos_o  <= pos_i;
      sel_o  <= sel_i;
    end
  end
endmodule
`default_nettype wire

/* rtl/psd_sqrt_cell.sv */
`default_nettype none
// One bit of the integer square root of the along radicand, by digit recurrence:
// two radicand bits enter the partial remainder and 4*root+1 is tried against it.
module psd_sqrt_cell (
  input  wire           clk_i,
  input  wire           en_i,
  input  psd_pkg::res_t res_i,
  output psd_pkg::res_t res_o
);
  import psd_pkg::*;
  logic [37:0] sh;
  logic [37:0] trial;
  res_t        nxt;

  always_comb begin
    sh      = {res_i.rem, res_i.rad[71:70]};
    trial   = {res_i.root, 2'b01};
    nxt     = res_i;
    nxt.rad = {res_i.rad[69:0], 2'b00};
    if (sh >= trial) begin
      nxt.rem  = 36'(sh - trial);
      nxt.root = {res_i.root[34:0], 1'b1};
    end else begin
      nxt.rem  = sh[35:0];
      nxt.root = {res_i.root[34:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_o <= nxt;
  end
endmodule
`default_nettype wire

/* rtl/point_segment_distance.sv */
// Throughput: one word per cycle; the pipeline stalls as a whole on m_axis_tready.
// The path is 4 front stages, a chain of 32 divider cells, 3 interpolation and
// sum stages, then 36 square-root cells.
// Reset clears all valid flags and sets zero_tolerance to 1; payload is not reset.
`default_nettype none
module point_segment_distance (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [31:0] cfg_data_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // point_x, point_y, point_z, start_x..z, end_x..z (32 bits each)
  input  wire [287:0] s_axis_tdata,
  // use_z
  input  wire         s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // dist_squared, near_x, near_y, near_z, along_distance, position_code, zero fill
  output logic [199:0] m_axis_tdata
);
  import psd_pkg::*;
  localparam int unsigned Stages = 4 + TBits + 3 + SqrtBits;

  logic [31:0] tol_q;
  logic [Stages-1:0] vld_q;
  logic en;

  assign en = ~vld_q[Stages-1] | m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = vld_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
      vld_q <= '0;
    end else begin
      if (cfg_valid_i) tol_q <= cfg_data_i;
      if (en) vld_q <= {vld_q[Stages-2:0], s_axis_tvalid};
    end
  end

  // Stage 0: differences.
  geom_t g0_q;
  logic signed [32:0] ix [9];
  logic [31:0] tol;
  logic [32:0] mx, my, mz;
  always_comb begin
    for (int i = 0; i < 9; i++) ix[i] = 33'(signed'(s_axis_tdata[32*i +: 32]));
    if (!s_axis_tuser) begin
      ix[2] = '0; ix[5] = '0; ix[8] = '0;
    end
  end
  assign tol = (tol_q == '0) ? TolReset : tol_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      g0_q.px <= ix[0]; g0_q.py <= ix[1]; g0_q.pz <= ix[2];
      g0_q.sx <= ix[3]; g0_q.sy <= ix[4]; g0_q.sz <= ix[5];
      g0_q.dx <= ix[6] - ix[3]; g0_q.dy <= ix[7] - ix[4]; g0_q.dz <= ix[8] - ix[5];
      g0_q.use_z <= s_axis_tuser;
      g0_q.degen <= 1'b0;
    end
  end
  always_comb begin
    mx = g0_q.dx[32] ? 33'(-g0_q.dx) : g0_q.dx;
    my = g0_q.dy[32] ? 33'(-g0_q.dy) : g0_q.dy;
    mz = g0_q.dz[32] ? 33'(-g0_q.dz) : g0_q.dz;
  end

  // Stage 1: products and degenerate test. Stage 2: sums. Stage 3: classify.
  geom_t g1_d;
  geom_t g1_q, g2_q, g3_q;
  logic signed [67:0] nm_q [3];
  logic [65:0] dn_q [3];
  logic signed [69:0] num_q;
  logic [69:0] den_q;
  always_comb begin
    g1_d = g0_q;
    g1_d.degen = (mx < {1'b0, tol}) && (my < {1'b0, tol}) && (mz < {1'b0, tol});
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_q <= g1_d;
      nm_q[0] <= 68'(g0_q.dx * (g0_q.px - g0_q.sx));
      nm_q[1] <= 68'(g0_q.dy * (g0_q.py - g0_q.sy));
      nm_q[2] <= 68'(g0_q.dz * (g0_q.pz - g0_q.sz));
      dn_q[0] <= 66'(mx * mx);
      dn_q[1] <= 66'(my * my);
      dn_q[2] <= 66'(mz * mz);
      g2_q  <= g1_q;
      num_q <= 70'(nm_q[0]) + 70'(nm_q[1]) + 70'(nm_q[2]);
      den_q <= 70'(dn_q[0]) + 70'(dn_q[1]) + 70'(dn_q[2]);
    end
  end

  div_t  d3_q;
  pos_e  p3_q, p3_d;
  sel_e  s3_q, s3_d;
  always_comb begin
    p3_d = POS_WITHIN;
    s3_d = SEL_START;
    if (!g2_q.degen) begin
      if (num_q[69] || num_q == '0) begin
        if (num_q[69]) p3_d = POS_BEFORE;
      end else if (num_q >= signed'(den_q)) begin
        s3_d = SEL_END;
        if (num_q != signed'(den_q)) p3_d = POS_PAST;
      end else begin
        s3_d = SEL_INNER;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      g3_q <= g2_q;
      d3_q.t <= '0; d3_q.rem <= num_q; d3_q.den <= den_q;
      p3_q <= p3_d;
      s3_q <= s3_d;
    end
  end

  div_t  dc [TBits+1];
  geom_t gc [TBits+1];
  pos_e  pc [TBits+1];
  sel_e  sc [TBits+1];
  assign dc[0] = d3_q; assign gc[0] = g3_q; assign pc[0] = p3_q; assign sc[0] = s3_q;
  for (genvar k = 0; k < TBits; k++) begin : g_div
    psd_div_cell u_cell (
      .clk_i, .en_i(en), .div_i(dc[k]), .geom_i(gc[k]), .pos_i(pc[k]), .sel_i(sc[k]),
      .div_o(dc[k+1]), .geom_o(gc[k+1]), .pos_o(pc[k+1]), .sel_o(sc[k+1]));
  end

  // Interpolation: product, round, select.
  geom_t gi, ga_q;
  pos_e  pa_q;
  sel_e  sa_q;
  logic [64:0] pr_q [3];
  logic ng_q [3];
  logic signed [32:0] dd [3];
  logic [32:0] dm [3];
  assign gi = gc[TBits];
  assign dd[0] = gi.dx; assign dd[1] = gi.dy; assign dd[2] = gi.dz;
  always_comb begin
    for (int i = 0; i < 3; i++) dm[i] = dd[i][32] ? 33'(-dd[i]) : dd[i];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ga_q <= gi; pa_q <= pc[TBits]; sa_q <= sc[TBits];
      for (int i = 0; i < 3; i++) begin
        pr_q[i] <= 65'(dm[i] * dc[TBits].t);
        ng_q[i] <= dd[i][32];
      end
    end
  end

  logic signed [32:0] sv [3], pv [3], nv [3], da [3];
  logic [65:0] rnd [3];
  assign sv[0] = ga_q.sx; assign sv[1] = ga_q.sy; assign sv[2] = ga_q.sz;
  assign pv[0] = ga_q.px; assign pv[1] = ga_q.py; assign pv[2] = ga_q.pz;
  assign da[0] = ga_q.dx; assign da[1] = ga_q.dy; assign da[2] = ga_q.dz;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = {1'b0, pr_q[i]} + (66'd1 << (TBits - 1));
      unique case (sa_q)
        // The end point is exactly s + d.
        SEL_END:   nv[i] = 33'(sv[i] + da[i]);
        SEL_INNER: nv[i] = ng_q[i] ? 33'(sv[i] - 33'(rnd[i] >> TBits))
                                   : 33'(sv[i] + 33'(rnd[i] >> TBits));
        default:   nv[i] = sv[i];
      endcase
    end
  end

  // Squares and sums.
  logic signed [31:0] nb_q [3];
  logic [65:0] q1_q [3], q2_q [3];
  pos_e pb_q;
  logic signed [33:0] e1 [3], e2 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = 34'(signed'(nv[i][31:0])) - 34'(pv[i]);
      e2[i] = 34'(signed'(nv[i][31:0])) - 34'(sv[i]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      pb_q <= pa_q;
      for (int i = 0; i < 3; i++) begin
        nb_q[i] <= nv[i][31:0];
        q1_q[i] <= 66'(e1[i] * e1[i]);
        q2_q[i] <= 66'(e2[i] * e2[i]);
      end
    end
  end

  res_t rc [SqrtBits+1];
  logic [67:0] sum1;
  assign sum1 = 68'(q1_q[0]) + 68'(q1_q[1]) + 68'(q1_q[2]);
  always_ff @(posedge clk_i) begin
    if (en) begin
      rc[0].dist2 <= (sum1[67:64] != '0) ? '1 : sum1[63:0];
      rc[0].rad   <= 72'(q2_q[0]) + 72'(q2_q[1]) + 72'(q2_q[2]);
      rc[0].rem   <= '0;
      rc[0].root  <= '0;
      rc[0].nx <= nb_q[0]; rc[0].ny <= nb_q[1]; rc[0].nz <= nb_q[2];
      rc[0].pos <= pb_q;
    end
  end
  for (genvar k = 0; k < SqrtBits; k++) begin : g_sqrt
    psd_sqrt_cell u_cell (
      .clk_i, .en_i(en), .res_i(rc[k]), .res_o(rc[k+1]));
  end

  res_t ro;
  assign ro = rc[SqrtBits];
  assign m_axis_tdata = {4'd0, ro.pos, ro.root[33:0], ro.nz, ro.ny, ro.nx, ro.dist2};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output word dropped");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[195:194] != 2'd3) else $error("bad position code");
endmodule
`default_nettype wire
